>>> hw/rtl/lli_pkg.sv
// Shared types and defaults for the two-line intersection pipeline.
// Used by line_line_intersection and lli_checker; no dependencies.
package lli_pkg;

    localparam int LLI_COORD_WIDTH = 16;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

endpackage

>>> hw/rtl/line_line_intersection.sv
// Two-line intersection by the determinant formula, signed Q12.4 in and out.
// Depends on lli_pkg (status codes, default coordinate width).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | i_valid / o_stall  | i_first_*, i_second_* (start/end x, y)
//  out     | source    | o_valid / i_stall  | o_cross_x, o_cross_y, o_status
//
// One beat per clock sustained while o_stall is low.
// The restoring divider resolves one quotient bit per stage, both lanes in step.
// Reset clears all valid bits (pipe, output and skid); datapath and output data registers are not reset.
// A two-entry output stage (output register + skid) lets the pipe keep accepting while a
// result waits; o_stall comes straight from the skid flag and freezes the whole pipe.
module line_line_intersection
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = LLI_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_first_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_cross_x,
    output logic signed [COORD_WIDTH-1:0] o_cross_y,
    output logic [1:0]                    o_status
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;       // coordinate differences
    localparam int PW   = 2 * W;       // coordinate products
    localparam int CW   = 2 * W + 1;   // cross terms c12, c34
    localparam int QW   = 2 * W + 2;   // denominator products, partial products
    localparam int DENW = 2 * W + 3;   // denominator
    localparam int MW   = 2 * W + 2;   // |denominator|
    localparam int NW   = 3 * W + 3;   // numerators
    localparam int NSTG = W + 8;

    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAXNEG = {1'b1, {(W-1){1'b0}}};

    logic            en;
    logic [NSTG-1:0] r_vld;
    logic            r_out_vld, r_skid_vld;

    assign en      = ~r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Stage A: differences and coordinate products
    logic signed [DW-1:0] r_a_dx12, r_a_dy12, r_a_dx34, r_a_dy34;
    logic signed [PW-1:0] r_a_p1, r_a_p2, r_a_p3, r_a_p4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx12 <= DW'(i_first_start_x) - DW'(i_first_end_x);
            r_a_dy12 <= DW'(i_first_start_y) - DW'(i_first_end_y);
            r_a_dx34 <= DW'(i_second_start_x) - DW'(i_second_end_x);
            r_a_dy34 <= DW'(i_second_start_y) - DW'(i_second_end_y);
            r_a_p1   <= PW'(i_first_start_x) * PW'(i_first_end_y);
            r_a_p2   <= PW'(i_first_start_y) * PW'(i_first_end_x);
            r_a_p3   <= PW'(i_second_start_x) * PW'(i_second_end_y);
            r_a_p4   <= PW'(i_second_start_y) * PW'(i_second_end_x);
        end
    end

    // Stage B: cross terms and denominator products
    logic signed [CW-1:0] r_b_c12, r_b_c34;
    logic signed [QW-1:0] r_b_q1, r_b_q2;
    logic signed [DW-1:0] r_b_dx12, r_b_dy12, r_b_dx34, r_b_dy34;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_c12  <= CW'(r_a_p1) - CW'(r_a_p2);
            r_b_c34  <= CW'(r_a_p3) - CW'(r_a_p4);
            r_b_q1   <= QW'(r_a_dx12) * QW'(r_a_dy34);
            r_b_q2   <= QW'(r_a_dy12) * QW'(r_a_dx34);
            r_b_dx12 <= r_a_dx12;
            r_b_dy12 <= r_a_dy12;
            r_b_dx34 <= r_a_dx34;
            r_b_dy34 <= r_a_dy34;
        end
    end

    // Stage C: denominator, numerator partial products (cross term split hi/lo)
    logic signed [DW-1:0]   c12_hi, c12_lo, c34_hi, c34_lo;
    logic signed [DENW-1:0] r_c_den;
    logic signed [QW-1:0]   r_c_xah, r_c_xal, r_c_xbh, r_c_xbl;
    logic signed [QW-1:0]   r_c_yah, r_c_yal, r_c_ybh, r_c_ybl;

    assign c12_hi = $signed(r_b_c12[CW-1:W]);
    assign c12_lo = $signed({1'b0, r_b_c12[W-1:0]});
    assign c34_hi = $signed(r_b_c34[CW-1:W]);
    assign c34_lo = $signed({1'b0, r_b_c34[W-1:0]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_den <= DENW'(r_b_q1) - DENW'(r_b_q2);
            r_c_xah <= QW'(c12_hi) * QW'(r_b_dx34);
            r_c_xal <= QW'(c12_lo) * QW'(r_b_dx34);
            r_c_xbh <= QW'(c34_hi) * QW'(r_b_dx12);
            r_c_xbl <= QW'(c34_lo) * QW'(r_b_dx12);
            r_c_yah <= QW'(c12_hi) * QW'(r_b_dy34);
            r_c_yal <= QW'(c12_lo) * QW'(r_b_dy34);
            r_c_ybh <= QW'(c34_hi) * QW'(r_b_dy12);
            r_c_ybl <= QW'(c34_lo) * QW'(r_b_dy12);
        end
    end

    // Stage D: recombine partials, denominator magnitude and sign
    logic signed [NW-1:0] r_d_xa, r_d_xb, r_d_ya, r_d_yb;
    logic [MW-1:0]        r_d_dmag;
    logic                 r_d_dneg, r_d_dzero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_xa    <= (NW'(r_c_xah) <<< W) + NW'(r_c_xal);
            r_d_xb    <= (NW'(r_c_xbh) <<< W) + NW'(r_c_xbl);
            r_d_ya    <= (NW'(r_c_yah) <<< W) + NW'(r_c_yal);
            r_d_yb    <= (NW'(r_c_ybh) <<< W) + NW'(r_c_ybl);
            r_d_dmag  <= MW'(r_c_den[DENW-1] ? -r_c_den : r_c_den);
            r_d_dneg  <= r_c_den[DENW-1];
            r_d_dzero <= (r_c_den == '0);
        end
    end

    // Stage E: numerators
    logic signed [NW-1:0] r_e_nx, r_e_ny;
    logic [MW-1:0]        r_e_dmag;
    logic                 r_e_dneg, r_e_dzero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_nx    <= r_d_xa - r_d_xb;
            r_e_ny    <= r_d_ya - r_d_yb;
            r_e_dmag  <= r_d_dmag;
            r_e_dneg  <= r_d_dneg;
            r_e_dzero <= r_d_dzero;
        end
    end

    // Stage F: numerator magnitudes, quotient signs
    logic [NW-1:0] r_f_umx, r_f_umy;
    logic [MW-1:0] r_f_dmag;
    logic          r_f_negx, r_f_negy, r_f_dzero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_umx   <= r_e_nx[NW-1] ? -r_e_nx : r_e_nx;
            r_f_umy   <= r_e_ny[NW-1] ? -r_e_ny : r_e_ny;
            r_f_negx  <= r_e_nx[NW-1] ^ r_e_dneg;
            r_f_negy  <= r_e_ny[NW-1] ^ r_e_dneg;
            r_f_dmag  <= r_e_dmag;
            r_f_dzero <= r_e_dzero;
        end
    end

    // Divider: entry 0 takes the overflow check (quotient >= 2^W), entries 1..W
    // resolve one quotient bit each, MSB first.
    logic [NW-1:0] r_v_rx [0:W];
    logic [NW-1:0] r_v_ry [0:W];
    logic [W-1:0]  r_v_qx [0:W];
    logic [W-1:0]  r_v_qy [0:W];
    logic [MW-1:0] r_v_dm [0:W];
    logic          r_v_nx [0:W];
    logic          r_v_ny [0:W];
    logic          r_v_ox [0:W];
    logic          r_v_oy [0:W];
    logic          r_v_dz [0:W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_rx[0] <= r_f_umx;
            r_v_ry[0] <= r_f_umy;
            r_v_qx[0] <= '0;
            r_v_qy[0] <= '0;
            r_v_dm[0] <= r_f_dmag;
            r_v_nx[0] <= r_f_negx;
            r_v_ny[0] <= r_f_negy;
            r_v_ox[0] <= r_f_umx >= (NW'(r_f_dmag) << W);
            r_v_oy[0] <= r_f_umy >= (NW'(r_f_dmag) << W);
            r_v_dz[0] <= r_f_dzero;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_div
        localparam int SH = W - k;
        logic [NW-1:0] trial;
        logic          ge_x, ge_y;

        always_comb begin
            trial = NW'(r_v_dm[k-1]) << SH;
            ge_x  = r_v_rx[k-1] >= trial;
            ge_y  = r_v_ry[k-1] >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_v_rx[k] <= ge_x ? r_v_rx[k-1] - trial : r_v_rx[k-1];
                r_v_ry[k] <= ge_y ? r_v_ry[k-1] - trial : r_v_ry[k-1];
                r_v_qx[k] <= r_v_qx[k-1] | (W'(ge_x) << SH);
                r_v_qy[k] <= r_v_qy[k-1] | (W'(ge_y) << SH);
                r_v_dm[k] <= r_v_dm[k-1];
                r_v_nx[k] <= r_v_nx[k-1];
                r_v_ny[k] <= r_v_ny[k-1];
                r_v_ox[k] <= r_v_ox[k-1];
                r_v_oy[k] <= r_v_oy[k-1];
                r_v_dz[k] <= r_v_dz[k-1];
            end
        end
    end

    // Stage H: saturate, apply sign, status
    logic [W-1:0] lim_x, lim_y, mag_x, mag_y;
    logic         sat_x, sat_y;
    logic [W-1:0] n_h_x, n_h_y;
    t_status      n_h_st;

    always_comb begin
        lim_x = r_v_nx[W] ? MAXNEG : MAXPOS;
        lim_y = r_v_ny[W] ? MAXNEG : MAXPOS;
        sat_x = r_v_ox[W] | (r_v_qx[W] > lim_x);
        sat_y = r_v_oy[W] | (r_v_qy[W] > lim_y);
        mag_x = sat_x ? lim_x : r_v_qx[W];
        mag_y = sat_y ? lim_y : r_v_qy[W];
        if (r_v_dz[W]) begin
            n_h_x  = '0;
            n_h_y  = '0;
            n_h_st = ST_PARALLEL;
        end else begin
            n_h_x  = r_v_nx[W] ? -mag_x : mag_x;
            n_h_y  = r_v_ny[W] ? -mag_y : mag_y;
            n_h_st = (sat_x | sat_y) ? ST_SAT : ST_VALID;
        end
    end

    logic [W-1:0] r_h_x, r_h_y;
    t_status      r_h_st;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_x  <= n_h_x;
            r_h_y  <= n_h_y;
            r_h_st <= n_h_st;
        end
    end

    // Output register plus skid entry
    logic [W-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    t_status      r_out_st, r_skid_st;
    logic         take, arrive, ld_from_skid, ld_from_pipe, ld_skid;
    logic         n_out_vld, n_skid_vld;

    always_comb begin
        take         = r_out_vld & ~i_stall;
        arrive       = en & r_vld[NSTG-1];
        ld_from_skid = r_skid_vld & take;
        ld_from_pipe = arrive & (~r_out_vld | take);
        ld_skid      = arrive & r_out_vld & ~take;
        n_out_vld    = r_out_vld;
        n_skid_vld   = r_skid_vld;
        if (ld_from_skid) begin
            n_skid_vld = 1'b0;
        end else if (ld_from_pipe) begin
            n_out_vld = 1'b1;
        end else if (ld_skid) begin
            n_skid_vld = 1'b1;
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_from_skid) begin
            r_out_x  <= r_skid_x;
            r_out_y  <= r_skid_y;
            r_out_st <= r_skid_st;
        end else if (ld_from_pipe) begin
            r_out_x  <= r_h_x;
            r_out_y  <= r_h_y;
            r_out_st <= r_h_st;
        end
        if (ld_skid) begin
            r_skid_x  <= r_h_x;
            r_skid_y  <= r_h_y;
            r_skid_st <= r_h_st;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_cross_x = $signed(r_out_x);
    assign o_cross_y = $signed(r_out_y);
    assign o_status  = r_out_st;

endmodule

>>> hw/rtl/lli_checker.sv
// Port-level assertions for line_line_intersection, attached by bind.
// Depends on lli_pkg (status codes).
module lli_checker
    import lli_pkg::*;
#(
    parameter int COORD_WIDTH = LLI_COORD_WIDTH
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_stall,
    input logic                          o_valid,
    input logic                          o_stall,
    input logic signed [COORD_WIDTH-1:0] o_cross_x,
    input logic signed [COORD_WIDTH-1:0] o_cross_y,
    input logic [1:0]                    o_status
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cross_x) && $stable(o_cross_y)
            && $stable(o_status))
        else $error("stalled output beat changed");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_PARALLEL |-> o_cross_x == '0 && o_cross_y == '0)
        else $error("parallel result not zero");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_VALID || o_status == ST_PARALLEL || o_status == ST_SAT)
        else $error("unknown status code");

    // input side only backs up when a result is already waiting
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without output stall");

endmodule

bind line_line_intersection lli_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lli_checker (.*);
